>>> rtl/hsa_pkg.sv
// Shared types, codes and constants for the histogram statistics accumulator.
// No dependencies.
`default_nettype none

package hsa_pkg;

    // Item kind carried in s_tuser
    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_READ   = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_IGNORE = 2'd3
    } kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_RANGE_TOP    = 2'd0,
        CFG_RANGE_BOTTOM = 2'd1,
        CFG_BIN_RECIP    = 2'd2,
        CFG_BINS_IN_USE  = 2'd3
    } cfg_index_t;

    localparam int SAMPLE_W   = 16;
    localparam int RECIP_W    = 24;
    localparam int COUNT_W    = 32;
    localparam int SUM_W      = 48;
    localparam int SUMSQ_W    = 63;
    localparam int SQ_W       = 31;
    localparam int BIN_IDX_W  = 7;
    localparam int NBINS_W    = 8;
    localparam int PROD_W     = 40;
    localparam int FRAC_BITS  = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 248;

    // Register reset values
    localparam logic signed [SAMPLE_W-1:0] TOP_RESET    = 16'sd1293;
    localparam logic signed [SAMPLE_W-1:0] BOTTOM_RESET = -16'sd1293;
    localparam logic [RECIP_W-1:0]         RECIP_RESET  = 24'd2560;
    localparam logic [NBINS_W-1:0]         NBINS_RESET  = 8'd101;

    // Statistics reset values
    localparam logic signed [SAMPLE_W-1:0] MAX_RESET = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] MIN_RESET = 16'sh7fff;
    localparam logic [COUNT_W-1:0]         COUNT_MAX = '1;
    localparam logic [SUMSQ_W-1:0]         SUMSQ_MAX = '1;

    // Saturating counter increment
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        sat_inc = (c == COUNT_MAX) ? c : c + 32'd1;
    endfunction

endpackage

`default_nettype wire

>>> rtl/histogram_statistics_accumulator_top.sv
// Histogram with running statistics: bin counts in an on-chip RAM, running stats in registers.
// Depends on hsa_pkg.
`default_nettype none

// Usage
// Slave stream (s_*): one item per handshake; s_tuser is the kind (sample, bin read,
// clear, ignored), s_tdata carries the sample and the bin index to read.
// Master stream (m_*): exactly one result per item, in order, carrying the hit bin,
// its count after the item and the running statistics after the item.
// cfg_we/cfg_index/cfg_data write the range edges, bin reciprocal and bin count; write
// only while no item is in flight.
// Path: an item passes the input register, the multiply, the RAM read and the
// read-modify-write of the bin; its result is then held in the output register for m_tvalid.
// Throughput: one item per cycle unless stalled. Back-to-back samples to the same bin are
// handled by forwarding the value written in read-modify-write to the following read.
// Reset: statistics return to their reset values and every bin reads as zero at once
// through a per-bin valid bit; no clearing pass. A clear item does the same.
// Stall: results land in an output register backed by one skid entry; s_tready falls
// only while the skid entry is occupied, and items already in the pipeline hold.
module histogram_statistics_accumulator_top
    import hsa_pkg::*;
#(
    parameter int MAX_BINS = 128
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [RECIP_W-1:0]    cfg_data,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // sample[15:0], read_index[22:16], pad
    input  wire logic [1:0]            s_tuser,   // kind[1:0]
    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata    // in_range, bin_index[7:1], bin_count,
                                                  // raw_count, hist_count, data_max,
                                                  // data_min, data_sum, data_sum_sq, pad
);

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    // ---------------------------------------------------------------
    // Configuration registers
    logic signed [SAMPLE_W-1:0] top_reg;
    logic signed [SAMPLE_W-1:0] bottom_reg;
    logic [RECIP_W-1:0]         recip_reg;
    logic [NBINS_W-1:0]         nbins_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg    <= TOP_RESET;
            bottom_reg <= BOTTOM_RESET;
            recip_reg  <= RECIP_RESET;
            nbins_reg  <= NBINS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_RANGE_TOP:    top_reg    <= cfg_data[SAMPLE_W-1:0];
                CFG_RANGE_BOTTOM: bottom_reg <= cfg_data[SAMPLE_W-1:0];
                CFG_BIN_RECIP:    recip_reg  <= cfg_data;
                CFG_BINS_IN_USE:  nbins_reg  <= cfg_data[NBINS_W-1:0];
                default:          top_reg    <= top_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline enable: advance unless the skid entry is occupied
    logic skid_valid_reg;
    logic en;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    logic s_accept;
    assign s_accept = s_tvalid && en;

    // ---------------------------------------------------------------
    // Stage 1: input register, range check, distance from top edge
    logic signed [SAMPLE_W-1:0] in_sample;
    logic signed [SAMPLE_W:0]   in_diff;
    logic                       in_hit;
    assign in_sample = s_tdata[SAMPLE_W-1:0];
    assign in_diff   = {top_reg[SAMPLE_W-1], top_reg} - {in_sample[SAMPLE_W-1], in_sample};
    assign in_hit    = (bottom_reg < in_sample) && (in_sample <= top_reg);

    logic                       p1_valid_reg;
    kind_t                      p1_kind_reg;
    logic signed [SAMPLE_W-1:0] p1_sample_reg;
    logic [BIN_IDX_W-1:0]       p1_ridx_reg;
    logic                       p1_hit_reg;
    logic [SAMPLE_W-1:0]        p1_diff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (en)
            p1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            p1_kind_reg   <= kind_t'(s_tuser);
            p1_sample_reg <= in_sample;
            p1_ridx_reg   <= s_tdata[SAMPLE_W +: BIN_IDX_W];
            p1_hit_reg    <= in_hit;
            p1_diff_reg   <= in_diff[SAMPLE_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: bin position product and sample square
    logic                       p2_valid_reg;
    kind_t                      p2_kind_reg;
    logic signed [SAMPLE_W-1:0] p2_sample_reg;
    logic [BIN_IDX_W-1:0]       p2_ridx_reg;
    logic                       p2_hit_reg;
    logic [PROD_W-1:0]          p2_prod_reg;
    logic [SQ_W-1:0]            p2_sq_reg;
    logic signed [2*SAMPLE_W-1:0] p1_sq;

    assign p1_sq = p1_sample_reg * p1_sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (en)
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en && p1_valid_reg)
        begin
            p2_kind_reg   <= p1_kind_reg;
            p2_sample_reg <= p1_sample_reg;
            p2_ridx_reg   <= p1_ridx_reg;
            p2_hit_reg    <= p1_hit_reg;
            p2_prod_reg   <= p1_diff_reg * recip_reg;
            p2_sq_reg     <= p1_sq[SQ_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage 2 combinational: clip the bin index, issue the RAM read
    logic [NBINS_W-1:0]            last_idx;
    logic [PROD_W-FRAC_BITS-1:0]   quot;
    logic [NBINS_W-1:0]            samp_idx;
    logic                          rd_oob;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;

    always_comb
    begin
        if (nbins_reg == '0)
            last_idx = '0;
        else if (32'(nbins_reg) > 32'(MAX_BINS))
            last_idx = NBINS_W'(MAX_BINS - 1);
        else
            last_idx = nbins_reg - 8'd1;
    end

    assign quot     = p2_prod_reg[PROD_W-1:FRAC_BITS];
    assign samp_idx = (quot > (PROD_W-FRAC_BITS)'(last_idx)) ? last_idx : quot[NBINS_W-1:0];
    assign rd_oob   = 32'(p2_ridx_reg) >= 32'(MAX_BINS);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = AW'(samp_idx);
        case (p2_kind_reg)
            KIND_SAMPLE:
            begin
                rd_en   = en && p2_valid_reg && p2_hit_reg;
                rd_addr = AW'(samp_idx);
            end
            KIND_READ:
            begin
                rd_en   = en && p2_valid_reg;
                rd_addr = AW'(p2_ridx_reg);
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = AW'(samp_idx);
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Bin count RAM and per-bin valid bits
    logic [COUNT_W-1:0] bin_mem [MAX_BINS];
    logic [MAX_BINS-1:0] bin_valid_reg;
    logic [COUNT_W-1:0]  mem_rd_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [COUNT_W-1:0]  mem_wd;
    logic                do_clear;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            bin_mem[mem_wa] <= mem_wd;
        if (rd_en)
            mem_rd_reg <= bin_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bin_valid_reg <= '0;
        else if (do_clear)
            bin_valid_reg <= '0;
        else if (mem_we)
            bin_valid_reg[mem_wa] <= 1'b1;
    end

    // ---------------------------------------------------------------
    // Stage 3: read-modify-write of the bin, with forwarding
    logic                       p3_valid_reg;
    kind_t                      p3_kind_reg;
    logic signed [SAMPLE_W-1:0] p3_sample_reg;
    logic [BIN_IDX_W-1:0]       p3_idx_reg;
    logic                       p3_hit_reg;
    logic [AW-1:0]              p3_addr_reg;
    logic                       p3_oob_reg;
    logic [SQ_W-1:0]            p3_sq_reg;
    logic                       p3_bvld_reg;
    logic                       p3_fwd_reg;
    logic [COUNT_W-1:0]         p3_fwd_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_valid_reg <= 1'b0;
        else if (en)
            p3_valid_reg <= p2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en && p2_valid_reg)
        begin
            p3_kind_reg   <= p2_kind_reg;
            p3_sample_reg <= p2_sample_reg;
            p3_hit_reg    <= p2_hit_reg;
            p3_addr_reg   <= rd_addr;
            p3_oob_reg    <= rd_oob;
            p3_sq_reg     <= p2_sq_reg;
            p3_bvld_reg   <= bin_valid_reg[rd_addr];
            p3_idx_reg    <= (p2_kind_reg == KIND_READ) ? p2_ridx_reg
                                                        : samp_idx[BIN_IDX_W-1:0];
            // a clear or a write to the same bin at this edge is not yet in the RAM
            if (do_clear)
            begin
                p3_fwd_reg     <= 1'b1;
                p3_fwd_val_reg <= '0;
            end
            else if (mem_we && (mem_wa == rd_addr))
            begin
                p3_fwd_reg     <= 1'b1;
                p3_fwd_val_reg <= mem_wd;
            end
            else
            begin
                p3_fwd_reg     <= 1'b0;
                p3_fwd_val_reg <= '0;
            end
        end
    end

    logic [COUNT_W-1:0] cur_count;
    logic [COUNT_W-1:0] new_count;
    logic               p3_go;
    logic               p3_sample_go;

    assign cur_count    = p3_fwd_reg ? p3_fwd_val_reg : (p3_bvld_reg ? mem_rd_reg : '0);
    assign new_count    = sat_inc(cur_count);
    assign p3_go        = en && p3_valid_reg;
    assign p3_sample_go = p3_go && (p3_kind_reg == KIND_SAMPLE);
    assign mem_we       = p3_sample_go && p3_hit_reg;
    assign mem_wa       = p3_addr_reg;
    assign mem_wd       = new_count;
    assign do_clear     = p3_go && (p3_kind_reg == KIND_CLEAR);

    // ---------------------------------------------------------------
    // Running statistics, updated as the item leaves stage 3
    logic [COUNT_W-1:0]         raw_reg, raw_next;
    logic [COUNT_W-1:0]         hist_reg, hist_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [SUMSQ_W-1:0]         sumsq_reg, sumsq_next;
    logic signed [SUM_W:0]      sum_ext;
    logic [SUMSQ_W:0]           sumsq_ext;

    assign sum_ext   = {sum_reg[SUM_W-1], sum_reg} + (SUM_W+1)'(p3_sample_reg);
    assign sumsq_ext = {1'b0, sumsq_reg} + (SUMSQ_W+1)'(p3_sq_reg);

    always_comb
    begin
        raw_next   = raw_reg;
        hist_next  = hist_reg;
        max_next   = max_reg;
        min_next   = min_reg;
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        if (do_clear)
        begin
            raw_next   = '0;
            hist_next  = '0;
            max_next   = MAX_RESET;
            min_next   = MIN_RESET;
            sum_next   = '0;
            sumsq_next = '0;
        end
        else if (p3_sample_go)
        begin
            raw_next = sat_inc(raw_reg);
            if (p3_hit_reg)
                hist_next = sat_inc(hist_reg);
            if (p3_sample_reg > max_reg)
                max_next = p3_sample_reg;
            if (p3_sample_reg < min_reg)
                min_next = p3_sample_reg;
            // saturate on signed overflow of the 48-bit sum
            if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
                sum_next = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                          : {1'b0, {(SUM_W-1){1'b1}}};
            else
                sum_next = sum_ext[SUM_W-1:0];
            sumsq_next = sumsq_ext[SUMSQ_W] ? SUMSQ_MAX : sumsq_ext[SUMSQ_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg   <= '0;
            hist_reg  <= '0;
            max_reg   <= MAX_RESET;
            min_reg   <= MIN_RESET;
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end
        else
        begin
            raw_reg   <= raw_next;
            hist_reg  <= hist_next;
            max_reg   <= max_next;
            min_reg   <= min_next;
            sum_reg   <= sum_next;
            sumsq_reg <= sumsq_next;
        end
    end

    // ---------------------------------------------------------------
    // Result assembly
    logic                 res_hit;
    logic [BIN_IDX_W-1:0] res_idx;
    logic [COUNT_W-1:0]   res_cnt;
    logic [OUT_DATA_W-1:0] res_data;

    always_comb
    begin
        res_hit = 1'b0;
        res_idx = '0;
        res_cnt = '0;
        case (p3_kind_reg)
            KIND_SAMPLE:
            begin
                res_hit = p3_hit_reg;
                res_idx = p3_hit_reg ? p3_idx_reg : '0;
                res_cnt = p3_hit_reg ? new_count : '0;
            end
            KIND_READ:
            begin
                res_idx = p3_idx_reg;
                res_cnt = p3_oob_reg ? '0 : cur_count;
            end
            default:
            begin
                res_hit = 1'b0;
            end
        endcase
    end

    assign res_data = {1'b0, sumsq_next, sum_next, min_next, max_next,
                       hist_next, raw_next, res_cnt, res_idx, res_hit};

    // ---------------------------------------------------------------
    // Output register and skid entry
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] skid_data_reg;
    logic                  pop;

    assign pop = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= p3_go;
        end
        else if (!out_valid_reg)
            out_valid_reg <= p3_go;
        else if (p3_go)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
            out_data_reg <= skid_data_reg;
        else if ((pop || !out_valid_reg) && p3_go)
            out_data_reg <= res_data;
        if (!pop && out_valid_reg && p3_go)
            skid_data_reg <= res_data;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------------------------------------------------------
    // Assertions
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds an item while the output register is empty");

    a_write_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (mem_wd != '0))
        else $error("bin written back with a zero count");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        do_clear |=> (bin_valid_reg == '0) && (raw_reg == '0))
        else $error("clear did not empty the bins and counters");

    a_hist_le_raw: assert property (@(posedge clk) disable iff (!rst_n)
        hist_reg <= raw_reg)
        else $error("histogram count exceeds raw count");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (raw_reg != '0) |-> (min_reg <= max_reg))
        else $error("minimum above maximum after samples");

endmodule

`default_nettype wire

>>> bench/tb_histogram_statistics_accumulator_top.sv
// Testbench for histogram_statistics_accumulator_top: a directed table, then random sample,
// bin read, clear and ignored items over several range settings, checked with a predictor.
// Depends on hsa_pkg and the RTL top level.
module tb_histogram_statistics_accumulator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hsa_pkg::*;

    localparam int NUM_BINS    = 128;
    localparam int PHASE_ITEMS = 80;
    localparam int NUM_PHASES  = 8;
    localparam int DRAIN_WAIT  = 20;

    // One result item, unpacked from m_tdata
    typedef struct packed {
        logic                       in_range;
        logic [BIN_IDX_W-1:0]       bin_index;
        logic [COUNT_W-1:0]         bin_count;
        logic [COUNT_W-1:0]         raw_count;
        logic [COUNT_W-1:0]         hist_count;
        logic signed [SAMPLE_W-1:0] data_max;
        logic signed [SAMPLE_W-1:0] data_min;
        logic signed [SUM_W-1:0]    data_sum;
        logic [SUMSQ_W-1:0]         data_sum_sq;
    } hist_result_t;

    // One row of the directed table
    typedef struct {
        kind_t                      kind;
        logic signed [SAMPLE_W-1:0] sample;
        logic [BIN_IDX_W-1:0]       read_index;
        bit                         typed;
        hist_result_t               want;
    } stim_row_t;

    // One register setting of the histogram range
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] top;
        logic signed [SAMPLE_W-1:0] bottom;
        logic [RECIP_W-1:0]         recip;
        logic [NBINS_W-1:0]         nbins;
    } range_cfg_t;

    localparam hist_result_t RESET_VIEW = '{1'b0, 7'd0, 32'd0, 32'd0, 32'd0,
                                            MAX_RESET, MIN_RESET, 48'sd0, 63'd0};
    localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;
    localparam logic [SUMSQ_W-1:0] SQ_LIMIT = '1;

    // Range settings walked by the random part: defaults, full span, clipping,
    // empty ranges, zero reciprocal and out-of-range bin counts
    localparam range_cfg_t RANGE_PLAN [NUM_PHASES] = '{
        '{16'sd1293,   -16'sd1293,  24'd2560,     8'd101},
        '{16'sd32767,  -16'sd32768, 24'd256,      8'd128},
        '{16'sd32767,  -16'sd32768, 24'hFFFFFF,   8'd255},
        '{16'sd200,    16'sd200,    24'd4096,     8'd0},
        '{16'sd500,    -16'sd500,   24'd6553,     8'd10},
        '{-16'sd32768, 16'sd32767,  24'd100,      8'd50},
        '{16'sd0,      -16'sd32768, 24'd0,        8'd1},
        '{-16'sd100,   -16'sd2000,  24'd3000,     8'd128}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [RECIP_W-1:0]    cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // sample[15:0], read_index[22:16], pad
    logic [1:0]            s_tuser = '0;   // kind[1:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // in_range, bin_index, bin_count, raw_count,
                                           // hist_count, data_max, data_min, data_sum,
                                           // data_sum_sq, pad

    // Predictor state and its copy of the registers
    logic [COUNT_W-1:0]         bin_model [NUM_BINS];
    logic [COUNT_W-1:0]         raw_total;
    logic [COUNT_W-1:0]         hist_total;
    logic signed [SAMPLE_W-1:0] peak_hi;
    logic signed [SAMPLE_W-1:0] peak_lo;
    longint                     sum_model;
    logic [SUMSQ_W-1:0]         sumsq_model;
    logic signed [SAMPLE_W-1:0] top_edge = TOP_RESET;
    logic signed [SAMPLE_W-1:0] bottom_edge = BOTTOM_RESET;
    logic [RECIP_W-1:0]         recip_model = RECIP_RESET;
    logic [NBINS_W-1:0]         bins_model = NBINS_RESET;

    hist_result_t expected_results [$];
    stim_row_t    directed_rows [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int n_checked = 0;
    int n_samples = 0;
    int n_hits = 0;
    int n_reads = 0;
    int n_clears = 0;
    int n_ignored = 0;

    histogram_statistics_accumulator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic void clear_model();
        foreach (bin_model[i])
            bin_model[i] = '0;
        raw_total   = '0;
        hist_total  = '0;
        peak_hi     = MAX_RESET;
        peak_lo     = MIN_RESET;
        sum_model   = 0;
        sumsq_model = '0;
    endfunction

    function automatic int bins_effective();
        if (bins_model == 0)
            return 1;
        if (bins_model > NUM_BINS)
            return NUM_BINS;
        return bins_model;
    endfunction

    // Works out the result of one accepted item and advances the predictor state
    function automatic hist_result_t predict_item(input kind_t kind,
                                                  input logic signed [SAMPLE_W-1:0] sample,
                                                  input logic [BIN_IDX_W-1:0] read_index);
        hist_result_t r;
        longint       s;
        longint       bin;
        logic [63:0]  sq;
        r = '0;
        case (kind)
            KIND_SAMPLE:
            begin
                s = sample;
                sq = s * s;
                raw_total = bump(raw_total);
                if (sample > peak_hi)
                    peak_hi = sample;
                if (sample < peak_lo)
                    peak_lo = sample;
                sum_model = sum_model + s;
                if (sum_model > SUM_HI)
                    sum_model = SUM_HI;
                if (sum_model < SUM_LO)
                    sum_model = SUM_LO;
                if ({1'b0, SQ_LIMIT - sumsq_model} < sq)
                    sumsq_model = SQ_LIMIT;
                else
                    sumsq_model = sumsq_model + sq[SUMSQ_W-1:0];
                if (s > longint'(bottom_edge) && s <= longint'(top_edge))
                begin
                    bin = ((longint'(top_edge) - s) * longint'(recip_model)) >>> FRAC_BITS;
                    if (bin > bins_effective() - 1)
                        bin = bins_effective() - 1;
                    bin_model[bin] = bump(bin_model[bin]);
                    hist_total = bump(hist_total);
                    r.in_range  = 1'b1;
                    r.bin_index = bin[BIN_IDX_W-1:0];
                    r.bin_count = bin_model[bin];
                end
            end
            KIND_READ:
            begin
                r.bin_index = read_index;
                r.bin_count = bin_model[read_index];
            end
            KIND_CLEAR:
                clear_model();
            default:
                ;
        endcase
        r.raw_count   = raw_total;
        r.hist_count  = hist_total;
        r.data_max    = peak_hi;
        r.data_min    = peak_lo;
        r.data_sum    = sum_model[SUM_W-1:0];
        r.data_sum_sq = sumsq_model;
        return r;
    endfunction

    function automatic void add_row(input kind_t kind, input logic signed [SAMPLE_W-1:0] sample,
                                    input logic [BIN_IDX_W-1:0] read_index, input bit typed,
                                    input hist_result_t want);
        stim_row_t row;
        row.kind       = kind;
        row.sample     = sample;
        row.read_index = read_index;
        row.typed      = typed;
        row.want       = want;
        directed_rows.push_back(row);
    endfunction

    // Random sample, mostly around the configured range
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int r;
        int span;
        int lo;
        int hi;
        r = $urandom_range(99);
        if (r < 20 || bottom_edge >= top_edge)
            return $urandom;
        if (r < 30)
        begin
            case ($urandom_range(3))
                0: return top_edge;
                1: return (top_edge == 16'sh7fff) ? top_edge : top_edge + 16'sd1;
                2: return bottom_edge;
                default: return bottom_edge + 16'sd1;
            endcase
        end
        span = int'(top_edge) - int'(bottom_edge);
        lo = int'(bottom_edge) - span / 8;
        hi = int'(top_edge) + span / 8;
        if (lo < -32768)
            lo = -32768;
        if (hi > 32767)
            hi = 32767;
        return lo + int'($urandom_range(hi - lo));
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (errors < 50)
            $display("%0t ns: %s mismatch, got %h expected %h", $time, field, got, want);
        errors++;
    endtask

    task automatic check_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(field, got, want);
    endtask

    // Result stall pattern
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each result item with the oldest expectation
    always @(posedge clk)
    begin
        hist_result_t got;
        hist_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.in_range    = m_tdata[0];
            got.bin_index   = m_tdata[7:1];
            got.bin_count   = m_tdata[39:8];
            got.raw_count   = m_tdata[71:40];
            got.hist_count  = m_tdata[103:72];
            got.data_max    = m_tdata[119:104];
            got.data_min    = m_tdata[135:120];
            got.data_sum    = m_tdata[183:136];
            got.data_sum_sq = m_tdata[246:184];
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", 64'(m_tdata[63:0]), '0);
            else
            begin
                want = expected_results.pop_front();
                n_checked++;
                check_field("in_range", got.in_range, want.in_range);
                check_field("bin_index", got.bin_index, want.bin_index);
                check_field("bin_count", got.bin_count, want.bin_count);
                check_field("raw_count", got.raw_count, want.raw_count);
                check_field("hist_count", got.hist_count, want.hist_count);
                check_field("data_max", got.data_max, want.data_max);
                check_field("data_min", got.data_min, want.data_min);
                check_field("data_sum", got.data_sum, want.data_sum);
                check_field("data_sum_sq", got.data_sum_sq, want.data_sum_sq);
            end
        end
    end

    // Offer one item, wait for it to be taken, then record what it should produce
    task automatic send_item(input kind_t kind, input logic signed [SAMPLE_W-1:0] sample,
                             input logic [BIN_IDX_W-1:0] read_index, input bit typed,
                             input hist_result_t want);
        hist_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, read_index, sample};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_item(kind, sample, read_index);
        expected_results.push_back(typed ? want : predicted);
        case (kind)
            KIND_SAMPLE:
            begin
                n_samples++;
                n_hits += predicted.in_range;
            end
            KIND_READ:  n_reads++;
            KIND_CLEAR: n_clears++;
            default:    n_ignored++;
        endcase
    endtask

    // Stop offering items until every expected result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Write all four registers on consecutive edges
    task automatic set_range(input range_cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RANGE_TOP;
        cfg_data  <= {{(RECIP_W - SAMPLE_W){c.top[SAMPLE_W-1]}}, c.top};
        @(posedge clk);
        top_edge = c.top;
        cfg_index <= CFG_RANGE_BOTTOM;
        cfg_data  <= {{(RECIP_W - SAMPLE_W){c.bottom[SAMPLE_W-1]}}, c.bottom};
        @(posedge clk);
        bottom_edge = c.bottom;
        cfg_index <= CFG_BIN_RECIP;
        cfg_data  <= c.recip;
        @(posedge clk);
        recip_model = c.recip;
        cfg_index <= CFG_BINS_IN_USE;
        cfg_data  <= RECIP_W'(c.nbins);
        @(posedge clk);
        bins_model = c.nbins;
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        hist_result_t first_hit;
        hist_result_t cleared_read;
        kind_t        kind;
        int           r;

        clear_model();
        first_hit    = '{1'b1, 7'd50, 32'd1, 32'd1, 32'd1, 16'sd0, 16'sd0, 48'sd0, 63'd0};
        cleared_read = RESET_VIEW;
        cleared_read.bin_index = 7'd50;

        // Directed table, run with the reset register values
        add_row(KIND_READ,   16'sh1234,   7'd0,   1'b1, RESET_VIEW);
        add_row(KIND_IGNORE, 16'shffff,   7'd127, 1'b1, RESET_VIEW);
        add_row(KIND_SAMPLE, 16'sd0,      7'd0,   1'b1, first_hit);
        add_row(KIND_SAMPLE, 16'sd1293,   7'd0,   1'b0, '0);  // top edge is inclusive
        add_row(KIND_SAMPLE, -16'sd1293,  7'd0,   1'b0, '0);  // bottom edge is exclusive
        add_row(KIND_SAMPLE, -16'sd1292,  7'd0,   1'b0, '0);  // last bin in use
        add_row(KIND_SAMPLE, 16'sd32767,  7'd127, 1'b0, '0);
        add_row(KIND_SAMPLE, -16'sd32768, 7'd0,   1'b0, '0);
        add_row(KIND_SAMPLE, 16'sd0,      7'd85,  1'b0, '0);
        add_row(KIND_SAMPLE, -16'sd1,     7'd42,  1'b0, '0);
        add_row(KIND_SAMPLE, 16'sh5555,   7'd0,   1'b0, '0);
        add_row(KIND_SAMPLE, 16'shaaaa,   7'd0,   1'b0, '0);
        add_row(KIND_SAMPLE, 16'sd256,    7'd0,   1'b0, '0);
        add_row(KIND_READ,   16'shffff,   7'd50,  1'b0, '0);
        add_row(KIND_READ,   16'sd0,      7'd0,   1'b0, '0);
        add_row(KIND_READ,   16'sd0,      7'd100, 1'b0, '0);
        add_row(KIND_READ,   16'sd0,      7'd127, 1'b0, '0);
        add_row(KIND_IGNORE, 16'sh1111,   7'd33,  1'b0, '0);  // stats stay as they are
        add_row(KIND_CLEAR,  16'sh7fff,   7'd127, 1'b1, RESET_VIEW);
        add_row(KIND_READ,   16'sd0,      7'd50,  1'b1, cleared_read);
        add_row(KIND_SAMPLE, 16'sd1293,   7'd0,   1'b0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 23;
        recv_idle_pct = 60;
        foreach (directed_rows[i])
            send_item(directed_rows[i].kind, directed_rows[i].sample,
                      directed_rows[i].read_index, directed_rows[i].typed,
                      directed_rows[i].want);

        // Random part: one register setting per phase, changed only while idle
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            set_range(RANGE_PLAN[p]);
            if (p >= 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (p >= 3)
            begin
                send_idle_pct = 60;
                recv_idle_pct = 23;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(99);
                if (r < 3)
                    kind = KIND_CLEAR;
                else if (r < 5)
                    kind = KIND_IGNORE;
                else if (r < 20)
                    kind = KIND_READ;
                else
                    kind = KIND_SAMPLE;
                send_item(kind,
                          (kind == KIND_SAMPLE) ? pick_sample() : $urandom,
                          $urandom_range(1) ? $urandom_range(127)
                                            : $urandom_range(bins_effective() - 1),
                          1'b0, '0);
                // hold off once mid-phase until the pipeline is empty
                if (p == 1 && n == PHASE_ITEMS / 2)
                    drain();
            end
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Checked %0d results: %0d samples (%0d binned), %0d bin reads, %0d clears,",
                 n_checked, n_samples, n_hits, n_reads, n_clears);
        $display("%0d ignored items, over %0d range settings incl. empty and clipped ranges.",
                 n_ignored, NUM_PHASES);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
